/* sv/deq_pkg.sv */
// Shared constants, codes and controller/datapath types for the deadline expiry queue.
`timescale 1ns / 1ps

package deq_pkg;

   // Storage and field sizes.
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 48;
   localparam int MAX_RESULTS = 16;
   localparam int RES_BITS    = 64;
   localparam int SEAT_BITS   = 32;
   localparam int DUR_BITS    = 32;
   localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
   localparam int DUE_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int EMIT_BITS   = $clog2(MAX_RESULTS);

   // Request action codes.
   typedef enum logic {
      ACT_SCHEDULE = 1'b0,
      ACT_TICK     = 1'b1
   } action_type;

   // Response kind codes.
   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_EXPIRED  = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCHED,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sched_take;
      logic tick_take;
      logic scan_start;
      logic scan_step;
      logic load_sched;
      logic load_emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic due_none;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

/* sv/deq_req_if.sv */
// Request channel interface: valid/ready handshake with the schedule or tick payload.
`timescale 1ns / 1ps

interface deq_req_if;
   logic                                valid;
   logic                                ready;
   deq_pkg::action_type                 action;
   logic [deq_pkg::RES_BITS-1:0]        reservation_in;
   logic [deq_pkg::SEAT_BITS-1:0]       seat_in;
   logic [deq_pkg::DUR_BITS-1:0]        duration_ticks;

   modport source (
      output valid, action, reservation_in, seat_in, duration_ticks,
      input  ready
   );

   modport sink (
      input  valid, action, reservation_in, seat_in, duration_ticks,
      output ready
   );
endinterface

/* sv/deq_rsp_if.sv */
// Response channel interface: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface deq_rsp_if;
   logic                                valid;
   logic                                ready;
   deq_pkg::kind_type                   kind;
   logic [deq_pkg::RES_BITS-1:0]        reservation_out;
   logic [deq_pkg::SEAT_BITS-1:0]       seat_out;
   logic                                last;

   modport source (
      output valid, kind, reservation_out, seat_out, last,
      input  ready
   );

   modport sink (
      input  valid, kind, reservation_out, seat_out, last,
      output ready
   );
endinterface

/* sv/deq_dp.sv */
// Datapath: time counter, slot table, expiry scan and response register.
`timescale 1ns / 1ps

module deq_dp (
   input  logic                clock,
   input  logic                reset,
   deq_req_if.sink             req_ch,
   deq_rsp_if.source           rsp_ch,
   input  deq_pkg::cmd_type    cmd,
   output deq_pkg::status_type status
);
   import deq_pkg::*;

   // Time and slot table.
   logic [TIME_BITS-1:0]   time_now_ff;
   logic [TIME_BITS-1:0]   time_now_in;
   logic [QUEUE_DEPTH-1:0] slot_valid_ff;
   logic [QUEUE_DEPTH-1:0] slot_valid_in;
   logic [TIME_BITS-1:0]   slot_expiry_ff [QUEUE_DEPTH];
   logic [RES_BITS-1:0]    slot_res_ff    [QUEUE_DEPTH];
   logic [SEAT_BITS-1:0]   slot_seat_ff   [QUEUE_DEPTH];

   // Schedule path.
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   queue_full;
   logic [TIME_BITS:0]     expiry_sum;
   logic [TIME_BITS-1:0]   sched_expiry;
   kind_type               pend_kind_ff;
   kind_type               pend_kind_in;

   // Scan path.
   logic [SLOT_BITS-1:0]   scan_idx_ff;
   logic [SLOT_BITS-1:0]   scan_idx_in;
   logic [SLOT_BITS-1:0]   best_idx_ff;
   logic [SLOT_BITS-1:0]   best_idx_in;
   logic [TIME_BITS-1:0]   best_exp_ff;
   logic [TIME_BITS-1:0]   best_exp_in;
   logic [DUE_BITS-1:0]    due_cnt_ff;
   logic [DUE_BITS-1:0]    due_cnt_in;
   logic [EMIT_BITS-1:0]   emitted_ff;
   logic [EMIT_BITS-1:0]   emitted_in;
   logic [TIME_BITS-1:0]   cur_exp;
   logic                   cur_due;
   logic                   emit_last;

   // Response register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   kind_type               rsp_kind_ff;
   logic [RES_BITS-1:0]    rsp_res_ff;
   logic [SEAT_BITS-1:0]   rsp_seat_ff;
   logic                   rsp_last_ff;
   logic                   out_free;

   // Lowest free slot and full flag.
   always_comb begin
      free_idx   = '0;
      queue_full = &slot_valid_ff;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_BITS'(i);
         end
      end
   end

   // Expiry of a new entry saturates at the largest time value.
   assign expiry_sum   = {1'b0, time_now_ff} + (TIME_BITS + 1)'(req_ch.duration_ticks);
   assign sched_expiry = expiry_sum[TIME_BITS] ? '1 : expiry_sum[TIME_BITS-1:0];

   // The time counter advances on a tick and sticks at its maximum.
   always_comb begin
      time_now_in = time_now_ff;
      if (cmd.tick_take && (time_now_ff != '1)) begin
         time_now_in = time_now_ff + TIME_BITS'(1);
      end
   end

   // Valid bits: set on a stored schedule, cleared on an emitted expiry.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.sched_take && !queue_full) begin
         slot_valid_in[free_idx] = 1'b1;
      end
      if (cmd.load_emit) begin
         slot_valid_in[best_idx_ff] = 1'b0;
      end
   end

   assign pend_kind_in = cmd.sched_take ? (queue_full ? KIND_REJECTED : KIND_ACCEPTED)
                                        : pend_kind_ff;

   // One slot is examined per scan cycle; strict compare keeps the lowest slot on ties.
   assign cur_exp = slot_expiry_ff[scan_idx_ff];
   assign cur_due = slot_valid_ff[scan_idx_ff] && (cur_exp <= time_now_ff);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      best_idx_in = best_idx_ff;
      best_exp_in = best_exp_ff;
      due_cnt_in  = due_cnt_ff;
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         due_cnt_in  = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + SLOT_BITS'(1);
         if (cur_due) begin
            due_cnt_in = due_cnt_ff + DUE_BITS'(1);
            if ((due_cnt_ff == '0) || (cur_exp < best_exp_ff)) begin
               best_idx_in = scan_idx_ff;
               best_exp_in = cur_exp;
            end
         end
      end
   end

   // Count of expiries delivered for the current tick.
   always_comb begin
      emitted_in = emitted_ff;
      if (cmd.tick_take) begin
         emitted_in = '0;
      end else if (cmd.load_emit) begin
         emitted_in = emitted_ff + EMIT_BITS'(1);
      end
   end

   assign emit_last = (due_cnt_ff == DUE_BITS'(1))
                   || (emitted_ff == EMIT_BITS'(MAX_RESULTS - 1));

   // The response register frees up when its transaction completes.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (cmd.load_sched || cmd.load_emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_now_ff   <= '0;
         slot_valid_ff <= '0;
         scan_idx_ff   <= '0;
         due_cnt_ff    <= '0;
         emitted_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         time_now_ff   <= time_now_in;
         slot_valid_ff <= slot_valid_in;
         scan_idx_ff   <= scan_idx_in;
         due_cnt_ff    <= due_cnt_in;
         emitted_ff    <= emitted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      best_idx_ff  <= best_idx_in;
      best_exp_ff  <= best_exp_in;
      if (cmd.sched_take && !queue_full) begin
         slot_expiry_ff[free_idx] <= sched_expiry;
         slot_res_ff[free_idx]    <= req_ch.reservation_in;
         slot_seat_ff[free_idx]   <= req_ch.seat_in;
      end
      if (cmd.load_sched) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_res_ff  <= '0;
         rsp_seat_ff <= '0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.load_emit) begin
         rsp_kind_ff <= KIND_EXPIRED;
         rsp_res_ff  <= slot_res_ff[best_idx_ff];
         rsp_seat_ff <= slot_seat_ff[best_idx_ff];
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.kind            = rsp_kind_ff;
   assign rsp_ch.reservation_out = rsp_res_ff;
   assign rsp_ch.seat_out        = rsp_seat_ff;
   assign rsp_ch.last            = rsp_last_ff;

   assign status.scan_last = (scan_idx_ff == SLOT_BITS'(QUEUE_DEPTH - 1));
   assign status.due_none  = (due_cnt_ff == '0);
   assign status.emit_last = emit_last;
   assign status.out_free  = out_free;

endmodule

/* sv/deq_ctrl.sv */
// Controller: sequences schedule handling, slot scans and expiry delivery.
`timescale 1ns / 1ps

module deq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  deq_pkg::action_type req_action,
   output logic                req_ready,
   input  deq_pkg::status_type status,
   output deq_pkg::cmd_type    cmd
);
   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_action == ACT_TICK) ? ST_SCAN : ST_SCHED;
            end
         end
         ST_SCHED: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.due_none) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               state_in = status.emit_last ? ST_IDLE : ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_TICK) begin
                  cmd.tick_take  = 1'b1;
                  cmd.scan_start = 1'b1;
               end else begin
                  cmd.sched_take = 1'b1;
               end
            end
         end
         ST_SCHED: begin
            cmd.load_sched = status.out_free;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_EMIT: begin
            if (!status.due_none && status.out_free) begin
               cmd.load_emit  = 1'b1;
               cmd.scan_start = !status.emit_last;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/deadline_expiry_queue.sv */
// Top level of the deadline expiry queue: controller plus datapath.
`timescale 1ns / 1ps

// Usage: the req_ch channel takes one transaction per item. A schedule
// transaction stores a reservation id and a seat id in the lowest free slot,
// with expiry at the current time plus its duration, and answers with one
// accepted or rejected (queue full) response. A tick transaction advances
// time by one and then delivers every due entry as an expired response,
// earliest expiry first, lowest slot on ties; the last one carries last.
// A tick with nothing due produces no response.
// Sequencing: a schedule response is loaded into the response register in
// the SCHED state once that register is free, and the block then takes the
// next request back in the idle state. A tick scans the 16-entry slot table
// one slot a cycle, then delivers the earliest due entry in the EMIT state
// once the response register is free, and repeats the scan for each further
// due entry; the block takes the next request after the last delivery. The
// repeated scan comes from the single compare unit of the scan.
// One item is handled at a time.
// The rsp_ch output is a register: a stalled receiver holds the block at
// the next delivery, and a new request is taken while a response waits.
// Reset (synchronous) clears time, all slots and the response register.

module deadline_expiry_queue (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_ch,
   deq_rsp_if.source rsp_ch
);
   import deq_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   // Sequencing.
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage, scan and response register.
   deq_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

/* verif/deq_expiry_checker.sv */
// Checker for the deadline expiry queue: watches both channels, predicts responses and compares.
`timescale 1ns / 1ps

module deq_expiry_checker (
   input  logic clock,
   input  logic reset,
   deq_req_if   req_mon,
   deq_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count
);
   import deq_pkg::*;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // One response as the block should deliver it.
   typedef struct {
      kind_type              kind;
      logic [RES_BITS-1:0]   reservation;
      logic [SEAT_BITS-1:0]  seat;
      logic                  last;
   } expiry_result_type;

   // Local copy of the block state.
   logic [TIME_BITS-1:0] tick_count;
   logic                 slot_busy        [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] slot_deadline    [QUEUE_DEPTH];
   logic [RES_BITS-1:0]  slot_reservation [QUEUE_DEPTH];
   logic [SEAT_BITS-1:0] slot_seat        [QUEUE_DEPTH];

   // Responses still owed by the block, oldest first.
   expiry_result_type expected_results[$];

   task automatic report_mismatch(input string what);
      $display("[%0t] deq_expiry_checker: %s", $realtime, what);
      error_count++;
   endtask

   // A schedule goes to the lowest free slot, with a saturating deadline.
   task automatic predict_schedule(input logic [RES_BITS-1:0] res,
                                   input logic [SEAT_BITS-1:0] seat,
                                   input logic [DUR_BITS-1:0] dur);
      int                free_slot;
      expiry_result_type answer;
      free_slot = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (!slot_busy[i] && free_slot < 0) begin
            free_slot = i;
         end
      end
      answer.reservation = '0;
      answer.seat        = '0;
      answer.last        = 1'b1;
      if (free_slot < 0) begin
         answer.kind = KIND_REJECTED;
      end else begin
         answer.kind = KIND_ACCEPTED;
         if (TIME_BITS'(dur) > TIME_MAX - tick_count) begin
            slot_deadline[free_slot] = TIME_MAX;
         end else begin
            slot_deadline[free_slot] = tick_count + TIME_BITS'(dur);
         end
         slot_busy[free_slot]        = 1'b1;
         slot_reservation[free_slot] = res;
         slot_seat[free_slot]        = seat;
      end
      expected_results.insert(expected_results.size(), answer);
   endtask

   // A tick advances time, then releases due entries earliest deadline first.
   task automatic predict_tick();
      int                best;
      int                emitted;
      expiry_result_type answer;
      emitted = 0;
      if (tick_count != TIME_MAX) begin
         tick_count = tick_count + TIME_BITS'(1);
      end
      while (emitted < MAX_RESULTS) begin
         best = -1;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (slot_busy[i] && slot_deadline[i] <= tick_count) begin
               if (best < 0 || slot_deadline[i] < slot_deadline[best]) begin
                  best = i;
               end
            end
         end
         if (best < 0) begin
            break;
         end
         slot_busy[best]    = 1'b0;
         answer.kind        = KIND_EXPIRED;
         answer.reservation = slot_reservation[best];
         answer.seat        = slot_seat[best];
         answer.last        = 1'b0;
         expected_results.insert(expected_results.size(), answer);
         emitted++;
      end
      if (emitted > 0) begin
         expected_results[expected_results.size() - 1].last = 1'b1;
      end
   endtask

   // Compare one delivered response with the oldest expectation.
   task automatic check_response();
      expiry_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected response kind %0d res %h seat %h",
                                   rsp_mon.kind, rsp_mon.reservation_out,
                                   rsp_mon.seat_out));
      end else begin
         want = expected_results.pop_front();
         if (rsp_mon.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, want %0d", rsp_mon.kind, want.kind));
         end
         if (rsp_mon.reservation_out !== want.reservation) begin
            report_mismatch($sformatf("reservation %h, want %h",
                                      rsp_mon.reservation_out, want.reservation));
         end
         if (rsp_mon.seat_out !== want.seat) begin
            report_mismatch($sformatf("seat %h, want %h", rsp_mon.seat_out, want.seat));
         end
         if (rsp_mon.last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b", rsp_mon.last, want.last));
         end
      end
   endtask

   // Sample every accepted transaction at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         tick_count = '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_busy[i] = 1'b0;
         end
         expected_results.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            check_response();
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.action == ACT_TICK) begin
               predict_tick();
            end else begin
               predict_schedule(req_mon.reservation_in, req_mon.seat_in,
                                req_mon.duration_ticks);
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the deadline expiry queue testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
   import deq_pkg::*;

   // No-handshake cycles allowed before the run is declared hung.
   localparam int IDLE_LIMIT   = 2000;
   // Drain time after the last response, longer than a full tick scan.
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_ITEMS = 450;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   idle_cycles;

   deq_req_if req_ch ();
   deq_rsp_if rsp_ch ();

   deadline_expiry_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   deq_expiry_checker expiry_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Drive one request transaction; entered and left at a falling edge.
   task automatic send_item(input action_type act, input logic [RES_BITS-1:0] res,
                            input logic [SEAT_BITS-1:0] seat,
                            input logic [DUR_BITS-1:0] dur);
      req_ch.valid          = 1'b1;
      req_ch.action         = act;
      req_ch.reservation_in = res;
      req_ch.seat_in        = seat;
      req_ch.duration_ticks = dur;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_schedule(input logic [DUR_BITS-1:0] dur);
      send_item(ACT_SCHEDULE, {$urandom(), $urandom()}, $urandom(), dur);
   endtask

   // The payload of a tick is ignored, so it carries noise.
   task automatic advance_tick();
      send_item(ACT_TICK, {$urandom(), $urandom()}, $urandom(), $urandom());
   endtask

   // Receiver: ready follows one of three stall patterns, chosen at random and rechosen over the run.
   initial begin
      int stall_mode;
      int stall_left;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall_mode = $urandom_range(0, 2);
         repeat (64) begin
            case (stall_mode)
               0: begin
                  rsp_ch.ready = 1'b1;
               end
               1: begin
                  rsp_ch.ready = ($urandom_range(0, 3) != 0);
               end
               default: begin
                  if (stall_left > 0) begin
                     rsp_ch.ready = 1'b0;
                     stall_left--;
                  end else begin
                     rsp_ch.ready = 1'b1;
                     if ($urandom_range(0, 5) == 0) begin
                        stall_left = $urandom_range(1, 12);
                     end
                  end
               end
            endcase
            @(negedge clock);
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin
      int burst_left;
      int gap;
      int sched_pct;
      int pick;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.action         = ACT_SCHEDULE;
      req_ch.reservation_in = '0;
      req_ch.seat_in        = '0;
      req_ch.duration_ticks = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero duration: the entry is due on the very next tick.
      send_item(ACT_SCHEDULE, '0, '0, '0);
      advance_tick();
      // Tick with nothing due gives no response.
      advance_tick();
      // All-ones fields; this entry stays stored for the whole run.
      send_item(ACT_SCHEDULE, '1, '1, '1);

      // Later deadline in a lower slot must still come out last.
      send_schedule(3);
      advance_tick();
      send_schedule(1);
      send_schedule(0);
      advance_tick();
      advance_tick();

      // Fill every free slot with one deadline, overflow it, then release all at once.
      repeat (QUEUE_DEPTH - 1) send_schedule(1);
      send_schedule($urandom_range(0, 5));
      advance_tick();

      // Random traffic in bursts, with the schedule share changing by phase.
      burst_left = 0;
      sched_pct  = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            pick      = $urandom_range(0, 2);
            sched_pct = (pick == 0) ? 35 : (pick == 1) ? 55 : 80;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_ch.valid = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         if ($urandom_range(1, 100) <= sched_pct) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               send_schedule(0);
            end else if (pick < 8) begin
               send_schedule($urandom_range(1, 8));
            end else begin
               send_schedule($urandom_range(9, 40));
            end
         end else begin
            advance_tick();
         end
      end
      req_ch.valid = 1'b0;

      // Wait for every owed response, then watch for strays.
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
